// File: hw/rtl/unit_owner_table_allocator_defines.svh
// Assertion macros shared by the allocator RTL.
// Each macro samples on clk and is disabled while rst_n is low.
`ifndef UNIT_OWNER_TABLE_ALLOCATOR_DEFINES_SVH
`define UNIT_OWNER_TABLE_ALLOCATOR_DEFINES_SVH

`define UOTA_ASSERT_HOLDS(label, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("allocator check failed");

`define UOTA_ASSERT_IMPLIES(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("allocator check failed");

`define UOTA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("allocator check failed");

`endif

// File: hw/rtl/uota_pkg.sv
`timescale 1ns / 1ps

package uota_pkg;

  localparam int UNITS_DEFAULT = 256;
  localparam int OWNER_W       = 8;
  localparam int COUNT_W       = 9;
  localparam int HOLE_W        = 8;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FAIL = 1'b1;

  typedef struct packed {
    logic clear;
    logic push;
    logic zero;
  } hole_ctl_t;

endpackage

// File: hw/rtl/uota_mem.sv
`timescale 1ns / 1ps

module uota_mem #(
  parameter int DEPTH = uota_pkg::UNITS_DEFAULT,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                         clk,
  input  logic                         we,
  input  logic [AW-1:0]                waddr,
  input  logic [uota_pkg::OWNER_W-1:0] wdata,
  input  logic                         re,
  input  logic [AW-1:0]                raddr,
  output logic [uota_pkg::OWNER_W-1:0] rdata
);
  import uota_pkg::*;

  logic [OWNER_W-1:0] mem [DEPTH];
  logic [OWNER_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: hw/rtl/uota_hole_counter.sv
`timescale 1ns / 1ps

module uota_hole_counter (
  input  logic                        clk,
  input  logic                        rst_n,
  input  uota_pkg::hole_ctl_t         ctl,
  output logic [uota_pkg::HOLE_W-1:0] holes
);
  import uota_pkg::*;

  logic              z1_r;
  logic              z2_r;
  logic              v1_r;
  logic              v2_r;
  logic              run_r;
  logic [HOLE_W-1:0] holes_r;
  logic              sat;

  assign sat = (holes_r == {HOLE_W{1'b1}});

  // An entry continues a run when it and the entry two places on are both
  // free. The window delays each entry by two so that decision can be made.
  always_ff @(posedge clk) begin
    if (!rst_n || ctl.clear) begin
      v1_r    <= 1'b0;
      v2_r    <= 1'b0;
      run_r   <= 1'b0;
      holes_r <= '0;
      z1_r    <= 1'b0;
      z2_r    <= 1'b0;
    end else if (ctl.push) begin
      z1_r <= ctl.zero;
      z2_r <= z1_r;
      v1_r <= 1'b1;
      v2_r <= v1_r;
      if (v2_r) begin
        if (z2_r && ctl.zero) begin
          run_r <= 1'b1;
        end else if (run_r) begin
          run_r <= 1'b0;
          if (!sat) begin
            holes_r <= holes_r + HOLE_W'(1);
          end
        end
      end
    end
  end

  // The last two entries never continue a run, so an open run closes there.
  assign holes = holes_r + HOLE_W'(run_r && !sat);

endmodule

// File: hw/rtl/unit_owner_table_allocator.sv
`timescale 1ns / 1ps

// Owner table allocator for UNITS memory units. Each transfer on the input
// channel is one request (allocate unit_count units to owner_id, or free every
// unit of owner_id) and yields exactly one result transfer with a status and
// the hole count of the updated table. The table lives in a single memory with
// a registered read, and each request walks it once, reading one entry and
// writing back the previous one each cycle; requests are handled one at a time.
// A result that is not yet taken holds the block in its final step and delays
// the next request. A count of free units is kept beside the table, so an
// allocate knows at acceptance whether it can be met. After reset the block
// clears every table entry before it accepts its first request.
module unit_owner_table_allocator #(
  parameter int UNITS = uota_pkg::UNITS_DEFAULT
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         in_operation,
  input  logic [uota_pkg::OWNER_W-1:0] in_owner_id,
  input  logic [uota_pkg::COUNT_W-1:0] in_unit_count,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         out_status,
  output logic [uota_pkg::HOLE_W-1:0]  out_hole_count
);
  import uota_pkg::*;

  `include "unit_owner_table_allocator_defines.svh"

  localparam int AW   = $clog2(UNITS);
  localparam int CW   = $clog2(UNITS + 1);
  localparam int CMPW = (CW > COUNT_W) ? CW : COUNT_W;

  localparam logic [1:0] ST_CLR  = 2'd0;
  localparam logic [1:0] ST_IDLE = 2'd1;
  localparam logic [1:0] ST_SCAN = 2'd2;
  localparam logic [1:0] ST_FIN  = 2'd3;

  logic [1:0]         state_r;
  logic [AW:0]        cnt_r;
  logic               rdv_r;
  logic [AW-1:0]      waddr_r;
  logic               op_r;
  logic [OWNER_W-1:0] id_r;
  logic [COUNT_W-1:0] want_r;
  logic               fail_r;
  logic [COUNT_W-1:0] given_r;
  logic               found_r;
  logic [CW-1:0]      zcnt_r;
  logic [CW-1:0]      free_cnt_r;
  logic               out_valid_r;
  logic               out_status_r;
  logic [HOLE_W-1:0]  out_hole_r;

  logic               in_xfer;
  logic               issue;
  logic               last_wr;
  logic               take;
  logic               hit;
  logic [OWNER_W-1:0] entry_nxt;
  logic               mem_we;
  logic [AW-1:0]      mem_waddr;
  logic [OWNER_W-1:0] mem_wdata;
  logic [OWNER_W-1:0] mem_rdata;
  logic [HOLE_W-1:0]  holes;
  hole_ctl_t          hctl;

  assign in_ready = (state_r == ST_IDLE);
  assign in_xfer  = in_valid && in_ready;
  assign issue    = (state_r == ST_SCAN) && (cnt_r < (AW + 1)'(UNITS));
  assign last_wr  = rdv_r && (waddr_r == AW'(UNITS - 1));

  always_comb begin
    take      = 1'b0;
    hit       = 1'b0;
    entry_nxt = mem_rdata;
    if (op_r == OP_ALLOC && !fail_r) begin
      if (mem_rdata == '0 && given_r < want_r) begin
        take      = 1'b1;
        entry_nxt = id_r;
      end
    end else if (mem_rdata == id_r) begin
      hit       = 1'b1;
      entry_nxt = '0;
    end
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = waddr_r;
    mem_wdata = entry_nxt;
    if (state_r == ST_CLR) begin
      mem_we    = 1'b1;
      mem_waddr = cnt_r[AW-1:0];
      mem_wdata = '0;
    end else if (state_r == ST_SCAN && rdv_r) begin
      mem_we = 1'b1;
    end
  end

  uota_mem #(
    .DEPTH(UNITS),
    .AW   (AW)
  ) u_mem (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .re   (issue),
    .raddr(cnt_r[AW-1:0]),
    .rdata(mem_rdata)
  );

  assign hctl.clear = in_xfer;
  assign hctl.push  = (state_r == ST_SCAN) && rdv_r;
  assign hctl.zero  = (entry_nxt == '0);

  uota_hole_counter u_holes (
    .clk  (clk),
    .rst_n(rst_n),
    .ctl  (hctl),
    .holes(holes)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLR;
      cnt_r       <= '0;
      rdv_r       <= 1'b0;
      free_cnt_r  <= CW'(UNITS);
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ready && (state_r != ST_FIN)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_CLR: begin
          cnt_r <= cnt_r + (AW + 1)'(1);
          if (cnt_r[AW-1:0] == AW'(UNITS - 1)) begin
            state_r <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_xfer) begin
            state_r <= ST_SCAN;
            cnt_r   <= '0;
            rdv_r   <= 1'b0;
            op_r    <= in_operation;
            id_r    <= in_owner_id;
            want_r  <= in_unit_count;
            fail_r  <= CMPW'(in_unit_count) > CMPW'(free_cnt_r);
            given_r <= '0;
            found_r <= 1'b0;
            zcnt_r  <= '0;
          end
        end
        ST_SCAN: begin
          rdv_r   <= issue;
          waddr_r <= cnt_r[AW-1:0];
          if (issue) begin
            cnt_r <= cnt_r + (AW + 1)'(1);
          end
          if (rdv_r) begin
            given_r <= given_r + COUNT_W'(take);
            found_r <= found_r || hit;
            zcnt_r  <= zcnt_r + CW'(entry_nxt == '0);
          end
          if (last_wr) begin
            state_r <= ST_FIN;
          end
        end
        ST_FIN: begin
          rdv_r <= 1'b0;
          if (!out_valid_r || out_ready) begin
            out_valid_r  <= 1'b1;
            out_status_r <= (op_r == OP_ALLOC) ? (fail_r ? STATUS_FAIL : STATUS_OK)
                                               : (found_r ? STATUS_OK : STATUS_FAIL);
            out_hole_r   <= holes;
            free_cnt_r   <= zcnt_r;
            state_r      <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_CLR;
        end
      endcase
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_hole_count = out_hole_r;

  `UOTA_ASSERT_IMPLIES(a_we_phase, mem_we, (state_r == ST_CLR) || (state_r == ST_SCAN))
  `UOTA_ASSERT_NEXT(a_accept_scan, in_xfer, (state_r == ST_SCAN) && (cnt_r == '0))
  `UOTA_ASSERT_HOLDS(a_free_bound, free_cnt_r <= CW'(UNITS))
  `UOTA_ASSERT_NEXT(a_last_fin, (state_r == ST_SCAN) && last_wr, state_r == ST_FIN)

endmodule

// File: tb/sv/unit_owner_table_allocator_tb.sv
`timescale 1ns / 1ps

module unit_owner_table_allocator_tb;
  import uota_pkg::*;

  localparam int UNITS              = UNITS_DEFAULT;
  localparam int RANDOM_REQUESTS    = 500;
  localparam int CALM_TAIL          = 60;
  localparam int HOLD_AFTER_RESULTS = 40;
  localparam int HOLD_OFF_CYCLES    = 1000;
  localparam int WATCHDOG_LIMIT     = 2 * HOLD_OFF_CYCLES + 8 * (UNITS + 3);

  typedef struct packed {
    logic              status;
    logic [HOLE_W-1:0] hole_count;
  } alloc_result_t;

  class owner_table_scoreboard #(int N = 256);
    logic [OWNER_W-1:0] units [N];
    alloc_result_t      expected_q [$];
    int                 errors;

    function new();
      foreach (units[i]) units[i] = '0;
      errors = 0;
    endfunction

    function int release_owner(logic [OWNER_W-1:0] id);
      int found = 0;
      foreach (units[i]) begin
        if (units[i] == id) begin
          units[i] = '0;
          found++;
        end
      end
      return found;
    endfunction

    // A run continues while entry i and entry i+2 are both free; entry i+1 is skipped.
    function logic [HOLE_W-1:0] count_holes();
      int holes = 0;
      bit in_run = 1'b0;
      for (int i = 0; i < N; i++) begin
        if (units[i] == '0 && i + 2 < N && units[i + 2] == '0) begin
          in_run = 1'b1;
        end else if (in_run) begin
          in_run = 1'b0;
          if (holes < 255) holes++;
        end
      end
      return holes[HOLE_W-1:0];
    endfunction

    function void note_request(logic op, logic [OWNER_W-1:0] id,
                               logic [COUNT_W-1:0] want);
      int            given = 0;
      alloc_result_t predicted;
      predicted.status = STATUS_OK;
      if (op == OP_ALLOC) begin
        foreach (units[i]) begin
          if (units[i] == '0 && given < want) begin
            units[i] = id;
            given++;
          end
        end
        if (given < want) begin
          void'(release_owner(id));
          predicted.status = STATUS_FAIL;
        end
      end else if (release_owner(id) == 0) begin
        predicted.status = STATUS_FAIL;
      end
      predicted.hole_count = count_holes();
      expected_q.push_back(predicted);
    endfunction

    function void check_result(logic status, logic [HOLE_W-1:0] hole_count);
      alloc_result_t predicted;
      if (expected_q.size() == 0) begin
        $error("result transfer with no request outstanding: status %0d hole_count %0d",
               status, hole_count);
        errors++;
        return;
      end
      predicted = expected_q.pop_front();
      if (status !== predicted.status) begin
        $error("status: expected %0d, actual %0d", predicted.status, status);
        errors++;
      end
      if (hole_count !== predicted.hole_count) begin
        $error("hole_count: expected %0d, actual %0d", predicted.hole_count, hole_count);
        errors++;
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic               clk           = 1'b0;
  logic               rst_n         = 1'b0;
  logic               in_valid      = 1'b0;
  logic               in_ready;
  logic               in_operation  = OP_ALLOC;
  logic [OWNER_W-1:0] in_owner_id   = '0;
  logic [COUNT_W-1:0] in_unit_count = '0;
  logic               out_valid;
  logic               out_ready     = 1'b0;
  logic               out_status;
  logic [HOLE_W-1:0]  out_hole_count;

  owner_table_scoreboard #(UNITS) sb;
  bit calm = 1'b0;
  int results_seen = 0;
  int idle_cycles = 0;

  unit_owner_table_allocator #(
    .UNITS(UNITS)
  ) uut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_operation  (in_operation),
    .in_owner_id   (in_owner_id),
    .in_unit_count (in_unit_count),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_status    (out_status),
    .out_hole_count(out_hole_count)
  );

  always #1 clk = ~clk;

  task automatic send_request(logic op, logic [OWNER_W-1:0] id, logic [COUNT_W-1:0] want);
    int gap;
    gap = 0;
    if (!calm && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 14);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_operation  <= op;
    in_owner_id   <= id;
    in_unit_count <= want;
    do @(posedge clk); while (!in_ready);
    sb.note_request(op, id, want);
  endtask

  task automatic run_directed();
    send_request(OP_ALLOC, 8'd1, 9'd0);
    send_request(OP_ALLOC, 8'd1, 9'd1);
    send_request(OP_ALLOC, 8'd2, 9'd3);
    send_request(OP_ALLOC, 8'd3, 9'd1);
    send_request(OP_ALLOC, 8'd4, 9'd2);
    send_request(OP_FREE, 8'd2, 9'd0);
    send_request(OP_FREE, 8'd2, 9'd511);
    send_request(OP_ALLOC, 8'd255, 9'd5);
    send_request(OP_ALLOC, 8'd0, 9'd3);
    send_request(OP_FREE, 8'd0, 9'd0);
    send_request(OP_ALLOC, 8'd5, 9'd257);
    send_request(OP_ALLOC, 8'd1, 9'd511);
    send_request(OP_FREE, 8'd3, 9'd0);
    send_request(OP_FREE, 8'd4, 9'd0);
    send_request(OP_FREE, 8'd255, 9'd0);
    send_request(OP_ALLOC, 8'd170, 9'd256);
    send_request(OP_FREE, 8'd0, 9'd0);
    send_request(OP_ALLOC, 8'd0, 9'd1);
    send_request(OP_ALLOC, 8'd0, 9'd0);
    send_request(OP_ALLOC, 8'd85, 9'd1);
    send_request(OP_FREE, 8'd170, 9'd0);
    send_request(OP_ALLOC, 8'd85, 9'd255);
    send_request(OP_ALLOC, 8'd86, 9'd2);
    send_request(OP_FREE, 8'd85, 9'd0);
  endtask

  task automatic run_random();
    logic [OWNER_W-1:0] pool [8];
    logic               op;
    logic [OWNER_W-1:0] id;
    logic [COUNT_W-1:0] want;
    int                 pick;
    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      if (n % 100 == 0) begin
        foreach (pool[k]) pool[k] = OWNER_W'($urandom_range(1, 255));
      end
      if (n == RANDOM_REQUESTS - CALM_TAIL) calm = 1'b1;
      pick = $urandom_range(0, 99);
      op   = OP_ALLOC;
      id   = pool[$urandom_range(0, 7)];
      want = COUNT_W'($urandom_range(1, 6));
      if (pick < 15) begin
        want = COUNT_W'($urandom_range(7, 40));
      end else if (pick < 20) begin
        want = COUNT_W'($urandom_range(0, 511));
      end else if (pick >= 50 && pick < 80) begin
        op   = OP_FREE;
        want = COUNT_W'($urandom_range(0, 511));
      end else if (pick >= 80 && pick < 88) begin
        op   = OP_FREE;
        id   = OWNER_W'($urandom_range(0, 255));
        want = COUNT_W'($urandom_range(0, 511));
      end else if (pick >= 88 && pick < 94) begin
        id   = '0;
        want = COUNT_W'($urandom_range(0, 511));
      end else if (pick >= 94) begin
        id   = OWNER_W'($urandom_range(0, 255));
        want = COUNT_W'($urandom_range(0, 511));
      end
      send_request(op, id, want);
    end
  endtask

  initial begin : stimulus
    sb = new();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    run_directed();
    run_random();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (UNITS + 16) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("unit_owner_table_allocator: match");
    end else begin
      $display("unit_owner_table_allocator: mismatch");
    end
    $finish;
  end

  // The receiver stalls in short random bursts, and once holds off long enough
  // that the block backs up and refuses the next request.
  initial begin : result_sink
    int stall;
    bit held;
    stall = 0;
    held  = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) begin
        sb.check_result(out_status, out_hole_count);
        results_seen++;
      end
      if (!held && results_seen == HOLD_AFTER_RESULTS) begin
        held  = 1'b1;
        stall = HOLD_OFF_CYCLES;
      end else if (stall == 0 && !calm && $urandom_range(0, 3) == 0) begin
        stall = $urandom_range(1, 14);
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        stall--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("unit_owner_table_allocator: mismatch");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

endmodule
